@@ rtl/mric_pkg.sv @@
// shared types, register codes and helpers for the mixed-radix index codec
// no dependencies; imported by mixed_radix_index_codec_top, mric_checker and testbench
`default_nettype none

package mric_pkg;

    // dimension count the ports are built for, and default used count
    localparam int MAX_DIMS     = 4;
    localparam int NUM_DIMS_DEF = 4;

    // field widths
    localparam int MIN_W   = 11;
    localparam int RANGE_W = 9;
    localparam int VALUE_W = 12;
    localparam int INDEX_W = 16;
    localparam int DEC_W   = 18;
    localparam int STRIDE_W = 25;
    localparam int TOTAL_W  = 33;

    // configuration port widths
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 96;

    // operation codes carried in s_tuser
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM0_MIN   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM1_MIN   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM2_MIN   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM3_MIN   = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM0_RANGE = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM1_RANGE = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM2_RANGE = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM3_RANGE = 8'd7;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REBUILD,
        ST_ENCODE,
        ST_DECODE,
        ST_FINISH
    } mric_state_t;

    // a range of zero acts as one, anything above 256 acts as 256
    function automatic logic [RANGE_W-1:0] range_eff(input logic [RANGE_W-1:0] r);
        logic [RANGE_W-1:0] res;
        res = r;
        if (r == '0) begin
            res = 9'd1;
        end else if (r > 9'd256) begin
            res = 9'd256;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mixed_radix_index_codec_top.sv @@
// mixed-radix index codec: encode values to a flat index, decode an index to values
// depends on mric_pkg
`default_nettype none

// Converts between up to NUM_DIMS bounded values and one flat mixed-radix index.
// The minimum and range of each dimension are set through the configuration
// channel (index 0..3 minimums, 4..7 ranges; other indexes are ignored). Every
// register write starts a rebuild of the strides and total count, one
// dimension per cycle through the shared multiplier, during which neither
// channel is ready. An encode transfer (s_tuser 0) does one multiply-accumulate
// per dimension. A decode transfer (s_tuser 1) runs a restoring divider that
// works one quotient bit per cycle, highest dimension first, and its remainder
// feeds the next dimension. One item is in work at a time; the result sits in
// an output register, so the next item is taken while it waits for m_tready.
module mixed_radix_index_codec_top #(
    parameter int NUM_DIMS = mric_pkg::NUM_DIMS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mric_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mric_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // value_0, value_1, value_2, value_3, flat_index
    input  wire logic [mric_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation
    input  wire logic                              s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // index_out, decoded_0, decoded_1, decoded_2, decoded_3, index_valid,
    // values_in_range, zero fill
    output logic [mric_pkg::M_TDATA_W-1:0]         m_tdata
);
    import mric_pkg::*;

    localparam logic [1:0] LAST_DIM = 2'(NUM_DIMS - 1);
    localparam logic [1:0] TOP_DIM  = 2'(MAX_DIMS - 1);

    // control registers
    mric_state_t state_reg, state_next;
    logic [1:0] dim_cnt_reg, dim_cnt_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic       out_valid_reg, out_valid_next;

    // configuration and derived state
    logic [MIN_W-1:0]    min_reg    [MAX_DIMS];
    logic [MIN_W-1:0]    min_next   [MAX_DIMS];
    logic [RANGE_W-1:0]  range_reg  [MAX_DIMS];
    logic [RANGE_W-1:0]  range_next [MAX_DIMS];
    logic [STRIDE_W-1:0] stride_reg [MAX_DIMS];
    logic [STRIDE_W-1:0] stride_next[MAX_DIMS];
    logic [TOTAL_W-1:0]  total_reg, total_next;

    // working registers
    logic                     op_reg, op_next;
    logic [VALUE_W-1:0]       value_reg [MAX_DIMS];
    logic [VALUE_W-1:0]       value_next[MAX_DIMS];
    logic [INDEX_W-1:0]       num_reg, num_next;
    logic [INDEX_W-1:0]       rem_reg, rem_next;
    logic [INDEX_W-1:0]       quo_reg, quo_next;
    logic [INDEX_W-1:0]       acc_reg, acc_next;
    logic                     inrange_reg, inrange_next;
    logic                     valid_reg, valid_next;
    logic signed [DEC_W-1:0]  dec_reg [MAX_DIMS];
    logic signed [DEC_W-1:0]  dec_next[MAX_DIMS];
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;

    // handshakes
    logic cfg_fire, in_fire, out_free;

    // shared multiplier
    logic [STRIDE_W-1:0]         mul_a;
    logic [INDEX_W-1:0]          mul_b;
    logic [STRIDE_W+INDEX_W-1:0] mul_p;

    // encode offset and divider step
    logic signed [VALUE_W:0] pos;
    logic [RANGE_W-1:0]      cur_range;
    logic                    pos_ok;
    logic [INDEX_W:0]        r_sh;
    logic                    div_ge;
    logic [INDEX_W-1:0]      rem_step;
    logic [INDEX_W-1:0]      quo_fin;

    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // dimension offset and range check for encode
    assign cur_range = (dim_cnt_reg <= LAST_DIM) ? range_eff(range_reg[dim_cnt_reg])
                                                 : RANGE_W'(1);
    assign pos = $signed({value_reg[dim_cnt_reg][VALUE_W-1], value_reg[dim_cnt_reg]})
               - $signed({{(VALUE_W+1-MIN_W){min_reg[dim_cnt_reg][MIN_W-1]}},
                          min_reg[dim_cnt_reg]});
    assign pos_ok = !pos[VALUE_W] &&
                    (pos[VALUE_W-1:0] < {{(VALUE_W-RANGE_W){1'b0}}, cur_range});

    // multiplier operands: stride product on rebuild, offset times stride on encode
    always_comb begin
        if (state_reg == ST_REBUILD) begin
            mul_a = total_reg[STRIDE_W-1:0];
            mul_b = {{(INDEX_W-RANGE_W){1'b0}}, cur_range};
        end else begin
            mul_a = {{(STRIDE_W-INDEX_W){1'b0}}, stride_reg[dim_cnt_reg][INDEX_W-1:0]};
            mul_b = {{(INDEX_W-VALUE_W-1){pos[VALUE_W]}}, pos};
        end
    end
    assign mul_p = mul_a * mul_b;

    // one restoring division step
    assign r_sh     = {rem_reg, num_reg[INDEX_W-1]};
    assign div_ge   = {{(STRIDE_W-INDEX_W-1){1'b0}}, r_sh} >= stride_reg[dim_cnt_reg];
    assign rem_step = div_ge ? INDEX_W'(r_sh - stride_reg[dim_cnt_reg][INDEX_W:0])
                             : r_sh[INDEX_W-1:0];
    assign quo_fin  = {quo_reg[INDEX_W-2:0], div_ge};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_fire) begin
                    state_next = ST_REBUILD;
                end else if (in_fire) begin
                    state_next = (s_tuser == OP_DECODE) ? ST_DECODE : ST_ENCODE;
                end
            end
            ST_REBUILD: begin
                if (dim_cnt_reg == TOP_DIM) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENCODE: begin
                if (dim_cnt_reg == LAST_DIM) begin
                    state_next = ST_FINISH;
                end
            end
            ST_DECODE: begin
                if (bit_cnt_reg == 4'd15 && dim_cnt_reg == 2'd0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        cfg_ready = (state_reg == ST_IDLE);
        s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
        m_tvalid  = out_valid_reg;
        m_tdata   = out_data_reg;
    end

    // datapath and counters
    always_comb begin
        dim_cnt_next   = dim_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        min_next       = min_reg;
        range_next     = range_reg;
        stride_next    = stride_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        acc_next       = acc_reg;
        inrange_next   = inrange_reg;
        valid_next     = valid_reg;
        dec_next       = dec_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_fire) begin
                    // register write, then rebuild strides from scratch
                    unique case (cfg_index) inside
                        CFG_DIM0_MIN, CFG_DIM1_MIN, CFG_DIM2_MIN, CFG_DIM3_MIN: begin
                            min_next[cfg_index[1:0]] = cfg_data[MIN_W-1:0];
                        end
                        CFG_DIM0_RANGE, CFG_DIM1_RANGE, CFG_DIM2_RANGE, CFG_DIM3_RANGE: begin
                            range_next[cfg_index[1:0]] = cfg_data[RANGE_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                    total_next   = TOTAL_W'(1);
                    dim_cnt_next = 2'd0;
                end else if (in_fire) begin
                    // capture the item and clear the accumulators
                    op_next = s_tuser;
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        value_next[d] = s_tdata[d*VALUE_W +: VALUE_W];
                        dec_next[d]   = '0;
                    end
                    num_next     = s_tdata[MAX_DIMS*VALUE_W +: INDEX_W];
                    rem_next     = '0;
                    quo_next     = '0;
                    acc_next     = '0;
                    inrange_next = 1'b1;
                    valid_next   = {{(TOTAL_W-INDEX_W){1'b0}},
                                    s_tdata[MAX_DIMS*VALUE_W +: INDEX_W]} < total_reg;
                    bit_cnt_next = 4'd0;
                    dim_cnt_next = (s_tuser == OP_DECODE) ? LAST_DIM : 2'd0;
                end
            end
            ST_REBUILD: begin
                // stride of this dimension is the product so far
                stride_next[dim_cnt_reg] = total_reg[STRIDE_W-1:0];
                total_next   = mul_p[TOTAL_W-1:0];
                dim_cnt_next = dim_cnt_reg + 2'd1;
            end
            ST_ENCODE: begin
                acc_next     = acc_reg + mul_p[INDEX_W-1:0];
                inrange_next = inrange_reg && pos_ok;
                dim_cnt_next = dim_cnt_reg + 2'd1;
            end
            ST_DECODE: begin
                if (bit_cnt_reg == 4'd15) begin
                    // quotient done: remainder is the next dividend
                    dec_next[dim_cnt_reg] = $signed({2'b00, quo_fin})
                        + $signed({{(DEC_W-MIN_W){min_reg[dim_cnt_reg][MIN_W-1]}},
                                   min_reg[dim_cnt_reg]});
                    num_next     = rem_step;
                    rem_next     = '0;
                    quo_next     = '0;
                    dim_cnt_next = dim_cnt_reg - 2'd1;
                end else begin
                    num_next = {num_reg[INDEX_W-2:0], 1'b0};
                    rem_next = rem_step;
                    quo_next = quo_fin;
                end
                bit_cnt_next = bit_cnt_reg + 4'd1;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (op_reg == OP_DECODE) begin
                        out_data_next[INDEX_W-1:0] = '0;
                        out_data_next[INDEX_W+MAX_DIMS*DEC_W]   = valid_reg;
                        out_data_next[INDEX_W+MAX_DIMS*DEC_W+1] = valid_reg;
                        for (int d = 0; d < MAX_DIMS; d++) begin
                            out_data_next[INDEX_W+d*DEC_W +: DEC_W] = dec_reg[d];
                        end
                    end else begin
                        out_data_next[INDEX_W-1:0] = acc_reg;
                        out_data_next[INDEX_W+MAX_DIMS*DEC_W+1] = inrange_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control and configuration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dim_cnt_reg   <= 2'd0;
            bit_cnt_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
            total_reg     <= TOTAL_W'(1);
            for (int d = 0; d < MAX_DIMS; d++) begin
                min_reg[d]    <= '0;
                range_reg[d]  <= RANGE_W'(1);
                stride_reg[d] <= STRIDE_W'(1);
            end
        end else begin
            state_reg     <= state_next;
            dim_cnt_reg   <= dim_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            min_reg       <= min_next;
            range_reg     <= range_next;
            stride_reg    <= stride_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        acc_reg      <= acc_next;
        inrange_reg  <= inrange_next;
        valid_reg    <= valid_next;
        dec_reg      <= dec_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ sim/mric_checker.sv @@
// result checker for the mixed-radix index codec: tracks register writes,
// predicts one result per input transfer and compares it with the output stream
// depends on mric_pkg
module mric_checker #(
    parameter int NUM_DIMS = mric_pkg::NUM_DIMS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [mric_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mric_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [mric_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [mric_pkg::M_TDATA_W-1:0]    m_tdata,
    output int                                     conversion_mismatches,
    output int                                     conversions_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import mric_pkg::*;

    // input transfer layout, highest field first
    typedef struct packed {
        logic [INDEX_W-1:0] flat_index;
        logic [VALUE_W-1:0] value_3;
        logic [VALUE_W-1:0] value_2;
        logic [VALUE_W-1:0] value_1;
        logic [VALUE_W-1:0] value_0;
    } codec_item_t;

    // result transfer layout, highest field first
    typedef struct packed {
        logic [5:0]         zero_fill;
        logic               values_in_range;
        logic               index_valid;
        logic [DEC_W-1:0]   decoded_3;
        logic [DEC_W-1:0]   decoded_2;
        logic [DEC_W-1:0]   decoded_1;
        logic [DEC_W-1:0]   decoded_0;
        logic [INDEX_W-1:0] index_out;
    } codec_result_t;

    // register copies
    logic [MIN_W-1:0]   dim_min   [MAX_DIMS];
    logic [RANGE_W-1:0] dim_range [MAX_DIMS];

    codec_result_t pending_conversions [$];

    // number of values a dimension really spans
    function automatic longint span_of(int d);
        longint r;
        if (d >= NUM_DIMS) begin
            return 1;
        end
        r = longint'(dim_range[d]);
        if (r == 0) begin
            r = 1;
        end else if (r > 256) begin
            r = 256;
        end
        return r;
    endfunction

    // expected result of one conversion under the current registers
    function automatic codec_result_t predict_conversion(codec_item_t item, logic op);
        longint stride [MAX_DIMS];
        longint vals   [MAX_DIMS];
        longint dec    [MAX_DIMS];
        longint total;
        longint acc;
        longint pos;
        longint rem;
        longint q;
        int d;
        codec_result_t res;
        vals[0] = longint'($signed(item.value_0));
        vals[1] = longint'($signed(item.value_1));
        vals[2] = longint'($signed(item.value_2));
        vals[3] = longint'($signed(item.value_3));
        total = 1;
        for (d = 0; d < MAX_DIMS; d++) begin
            stride[d] = total;
            dec[d] = 0;
            total = total * span_of(d);
        end
        res = '0;
        if (op == OP_ENCODE) begin
            // weighted sum of offsets, wraps at 16 bits
            res.values_in_range = 1'b1;
            acc = 0;
            for (d = 0; d < NUM_DIMS; d++) begin
                pos = vals[d] - longint'($signed(dim_min[d]));
                if (pos < 0 || pos >= span_of(d)) begin
                    res.values_in_range = 1'b0;
                end
                acc = acc + pos * stride[d];
            end
            res.index_out = acc[INDEX_W-1:0];
        end else begin
            // peel digits off from the highest dimension down
            rem = longint'(item.flat_index);
            for (d = NUM_DIMS - 1; d >= 0; d--) begin
                q = rem / stride[d];
                rem = rem - q * stride[d];
                dec[d] = q + longint'($signed(dim_min[d]));
            end
            res.index_valid = (longint'(item.flat_index) < total);
            res.values_in_range = res.index_valid;
        end
        res.decoded_0 = dec[0][DEC_W-1:0];
        res.decoded_1 = dec[1][DEC_W-1:0];
        res.decoded_2 = dec[2][DEC_W-1:0];
        res.decoded_3 = dec[3][DEC_W-1:0];
        return res;
    endfunction

    task automatic note_failure(string msg);
        conversion_mismatches++;
        if (conversion_mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            note_failure($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    task automatic compare_result(codec_result_t want, codec_result_t got);
        check_field("index_out", want.index_out, got.index_out);
        check_field("decoded_0", $signed(want.decoded_0), $signed(got.decoded_0));
        check_field("decoded_1", $signed(want.decoded_1), $signed(got.decoded_1));
        check_field("decoded_2", $signed(want.decoded_2), $signed(got.decoded_2));
        check_field("decoded_3", $signed(want.decoded_3), $signed(got.decoded_3));
        check_field("index_valid", want.index_valid, got.index_valid);
        check_field("values_in_range", want.values_in_range, got.values_in_range);
        check_field("zero fill", want.zero_fill, got.zero_fill);
    endtask

    initial begin
        conversion_mismatches = 0;
        conversions_in_flight = 0;
    end

    // watch all three channels at each rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                dim_min[d] = '0;
                dim_range[d] = 9'd1;
            end
            pending_conversions.delete();
        end else begin
            // register write transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIM0_MIN: begin
                        dim_min[0] = cfg_data[MIN_W-1:0];
                    end
                    CFG_DIM1_MIN: begin
                        dim_min[1] = cfg_data[MIN_W-1:0];
                    end
                    CFG_DIM2_MIN: begin
                        dim_min[2] = cfg_data[MIN_W-1:0];
                    end
                    CFG_DIM3_MIN: begin
                        dim_min[3] = cfg_data[MIN_W-1:0];
                    end
                    CFG_DIM0_RANGE: begin
                        dim_range[0] = cfg_data[RANGE_W-1:0];
                    end
                    CFG_DIM1_RANGE: begin
                        dim_range[1] = cfg_data[RANGE_W-1:0];
                    end
                    CFG_DIM2_RANGE: begin
                        dim_range[2] = cfg_data[RANGE_W-1:0];
                    end
                    CFG_DIM3_RANGE: begin
                        dim_range[3] = cfg_data[RANGE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // result transfer against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (pending_conversions.size() == 0) begin
                    note_failure("result transfer with no conversion outstanding");
                end else begin
                    compare_result(pending_conversions.pop_front(), codec_result_t'(m_tdata));
                end
            end
            // input transfer
            if (s_tvalid && s_tready) begin
                pending_conversions.push_back(
                    predict_conversion(codec_item_t'(s_tdata), s_tuser));
            end
        end
        conversions_in_flight = pending_conversions.size();
    end

endmodule

@@ sim/testbench.sv @@
// top of the mixed-radix index codec testbench: clock, reset, register phases,
// directed and random conversions, random stalls and the final verdict
// depends on mric_pkg, mixed_radix_index_codec_top and mric_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mric_pkg::*;

    localparam int CODEC_DIMS   = NUM_DIMS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_CYCLES = 100;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    int conversion_mismatches;
    int conversions_in_flight;
    int results_seen = 0;
    int cycle_count = 0;
    int send_calm = 0;

    // stimulus-side view of the current minimums and spans
    int cur_min  [MAX_DIMS];
    int cur_span [MAX_DIMS];

    mixed_radix_index_codec_top #(
        .NUM_DIMS(CODEC_DIMS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    mric_checker #(
        .NUM_DIMS(CODEC_DIMS)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .conversion_mismatches(conversion_mismatches),
        .conversions_in_flight(conversions_in_flight)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // count result transfers
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
        end
    end

    // receiver: random stalls, calm stretches and one long hold-off
    initial begin : receiver
        int r;
        int len;
        int calm;
        bit held;
        calm = 0;
        held = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (calm > 0) begin
                calm--;
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (r < 2) begin
                calm = $urandom_range(50, 200);
            end else if (r < 70) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                len = (r < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                m_tready <= 1'b0;
                repeat (len) @(posedge aclk);
            end
        end
    end

    function automatic int span_of_raw(int raw);
        if (raw == 0) begin
            return 1;
        end else if (raw > 256) begin
            return 256;
        end
        return raw;
    endfunction

    function automatic longint index_count();
        longint p;
        p = 1;
        for (int d = 0; d < CODEC_DIMS; d++) begin
            p = p * cur_span[d];
        end
        return p;
    endfunction

    // one register write transfer, unused upper data bits random
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value, int width);
        logic [CFG_DATA_W-1:0] fill;
        fill = CFG_DATA_W'($urandom);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (fill << width) | (CFG_DATA_W'(value) & ((16'd1 << width) - 16'd1));
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // let every outstanding conversion come back, then a few quiet cycles
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (conversions_in_flight != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // new register phase: all eight registers plus one ignored index
    task automatic configure(int m0, int m1, int m2, int m3, int r0, int r1, int r2, int r3);
        drain();
        cur_min[0] = m0;
        cur_min[1] = m1;
        cur_min[2] = m2;
        cur_min[3] = m3;
        cur_span[0] = span_of_raw(r0);
        cur_span[1] = span_of_raw(r1);
        cur_span[2] = span_of_raw(r2);
        cur_span[3] = span_of_raw(r3);
        write_reg(CFG_DIM0_MIN, m0, MIN_W);
        write_reg(CFG_DIM1_MIN, m1, MIN_W);
        write_reg(CFG_DIM2_MIN, m2, MIN_W);
        write_reg(CFG_DIM3_MIN, m3, MIN_W);
        write_reg(CFG_DIM0_RANGE, r0, RANGE_W);
        write_reg(CFG_DIM1_RANGE, r1, RANGE_W);
        write_reg(CFG_DIM2_RANGE, r2, RANGE_W);
        write_reg(CFG_DIM3_RANGE, r3, RANGE_W);
        write_reg(CFG_INDEX_W'($urandom_range(int'(CFG_DIM3_RANGE) + 1, 255)),
                  $urandom, CFG_DATA_W);
        cfg_valid <= 1'b0;
    endtask

    // one input transfer after a random gap
    task automatic send_item(logic op, int v0, int v1, int v2, int v3, int idx);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else if (r < 2) begin
            send_calm = $urandom_range(20, 60);
        end else if (r < 40) begin
            gap = $urandom_range(1, 3);
        end else if (r < 45) begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {INDEX_W'(idx), VALUE_W'(v3), VALUE_W'(v2), VALUE_W'(v1), VALUE_W'(v0)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_encode(int v0, int v1, int v2, int v3);
        send_item(OP_ENCODE, v0, v1, v2, v3, $urandom);
    endtask

    task automatic send_decode(int idx);
        send_item(OP_DECODE, $urandom, $urandom, $urandom, $urandom, idx);
    endtask

    // random conversions, mostly well-formed
    task automatic random_conversions(int count);
        int v [MAX_DIMS];
        int r;
        int k;
        longint lim;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            for (int d = 0; d < MAX_DIMS; d++) begin
                v[d] = cur_min[d] + $urandom_range(0, cur_span[d] - 1);
            end
            lim = index_count();
            if (lim > 65536) begin
                lim = 65536;
            end
            if (r < 45) begin
                send_encode(v[0], v[1], v[2], v[3]);
            end else if (r < 55) begin
                // one dimension just outside its range
                k = $urandom_range(0, CODEC_DIMS - 1);
                v[k] = $urandom_range(0, 1) ? cur_min[k] - 1 : cur_min[k] + cur_span[k];
                send_encode(v[0], v[1], v[2], v[3]);
            end else if (r < 65) begin
                send_encode($urandom, $urandom, $urandom, $urandom);
            end else if (r < 90) begin
                send_decode($urandom_range(0, int'(lim) - 1));
            end else begin
                send_decode($urandom_range(0, 65535));
            end
        end
    endtask

    function automatic int random_min();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    function automatic int random_range_raw();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 511);
        end
        return $urandom_range(1, 12);
    endfunction

    // stimulus
    initial begin : stimulus
        int total;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ENCODE;
        for (int d = 0; d < MAX_DIMS; d++) begin
            cur_min[d] = 0;
            cur_span[d] = 1;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: every span one
        random_conversions(20);

        // mixed spans, dimension one written as zero
        configure(-3, 1023, -1024, 0, 5, 0, 256, 7);
        total = 5 * 256 * 7;
        send_encode(-3, 1023, -1024, 0);
        send_encode(1, 1023, -769, 6);
        send_encode(-4, 1023, -1024, 0);
        send_encode(-3, 1023, -1024, 7);
        send_encode(-3, 1022, -1024, 0);
        send_encode(-3, 1024, -768, 0);
        send_encode(-2048, -2048, -2048, -2048);
        send_encode(2047, 2047, 2047, 2047);
        send_encode(0, 0, 0, 0);
        send_encode(-1, -1, -1, -1);
        send_decode(0);
        send_decode(1);
        send_decode(4);
        send_decode(5);
        send_decode(1279);
        send_decode(1280);
        send_decode(total - 1);
        send_decode(total);
        send_decode(65535);
        send_decode(32768);
        random_conversions(120);

        // widest spans, lowest minimums: count beyond 16 bits, encode wraps
        configure(-1024, -1024, -1024, -1024, 256, 256, 256, 256);
        send_encode(1278, 1278, 1278, 1278);
        send_decode(65535);
        random_conversions(130);

        // oversized and zero range writes, highest minimums
        configure(1023, 1023, 1023, 1023, 511, 300, 0, 257);
        send_encode(1278, 1023, 1023, 1278);
        send_decode(65535);
        random_conversions(130);

        // random settings
        repeat (4) begin
            configure(random_min(), random_min(), random_min(), random_min(),
                      random_range_raw(), random_range_raw(), random_range_raw(),
                      random_range_raw());
            random_conversions(100);
        end

        // wait for the tail, then the verdict
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (conversion_mismatches == 0 && conversions_in_flight == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
